// ===== hw/rtl/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Shared types and fixed constants of the shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

	localparam int unsigned DATA_W    = 16;
	localparam int unsigned SLOT_W    = 4;
	localparam int unsigned COUNT_W   = 5;
	localparam logic [DATA_W-1:0] DATA_MAX = {DATA_W{1'b1}};

	// Pending-count saturation value carried along the chain.
	localparam logic [1:0] PEND_SAT = 2'd2;

	// Request kinds on the input stream.
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Load command broadcast to every cell.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] index;
		logic [DATA_W-1:0] arr;
		logic [DATA_W-1:0] bur;
	} srtf_load_t;

	// Best candidate so far, handed from cell to cell.
	typedef struct packed {
		logic              found;
		logic [1:0]        pend;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] arr;
		logic [DATA_W-1:0] bur;
	} srtf_link_t;

endpackage

// ===== hw/rtl/srtf_cell.sv =====
// ----------------------------------------------------------------------------
// SRTF task cell
// Holds one task slot and folds it into the running minimum from its neighbor.
// ----------------------------------------------------------------------------
module srtf_cell #(
	parameter int unsigned MAX_TASKS = 16,
	parameter int unsigned IDX       = 0,
	parameter int unsigned TIME_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [srtf_pkg::COUNT_W-1:0]    task_count,
	input  logic [TIME_BITS-1:0]            time_now,
	input  srtf_pkg::srtf_load_t            load,
	input  logic                            dec_en,
	input  logic [$clog2(MAX_TASKS)-1:0]    dec_idx,
	input  srtf_pkg::srtf_link_t            link_in,
	input  logic [$clog2(MAX_TASKS)-1:0]    idx_in,
	output srtf_pkg::srtf_link_t            link_out,
	output logic [$clog2(MAX_TASKS)-1:0]    idx_out
);
	import srtf_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_TASKS);
	localparam int unsigned TW    = (TIME_BITS > DATA_W) ? TIME_BITS : DATA_W;

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] arr_q;
	logic [DATA_W-1:0] bur_q;
	srtf_link_t        link_q;
	logic [IDX_W-1:0]  idx_q;

	logic       in_use;
	logic       active;
	logic       ready;
	logic       take;
	srtf_link_t link_nx;

	always_comb begin
		in_use = (32'(task_count) > IDX);
		active = in_use && (rem_q != '0);
		ready  = active && (TW'(arr_q) <= TW'(time_now));
		take   = ready && (!link_in.found || (rem_q < link_in.rem));
		link_nx = link_in;
		if (active && (link_in.pend != PEND_SAT)) begin
			link_nx.pend = link_in.pend + 2'd1;
		end
		if (take) begin
			link_nx.found = 1'b1;
			link_nx.rem   = rem_q;
			link_nx.arr   = arr_q;
			link_nx.bur   = bur_q;
		end
	end

	// Slot contents: written by a load, decremented when this slot ran.
	always_ff @(posedge clk) begin
		if (load.en && (32'(load.index) == IDX)) begin
			arr_q <= load.arr;
			bur_q <= load.bur;
			rem_q <= load.bur;
		end else if (dec_en && (dec_idx == IDX_W'(IDX))) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
			idx_q  <= '0;
		end else begin
			link_q <= link_nx;
			idx_q  <= take ? IDX_W'(IDX) : idx_in;
		end
	end

	assign link_out = link_q;
	assign idx_out  = idx_q;

endmodule

// ===== hw/rtl/shortest_remaining_time_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Shortest-remaining-time-first scheduler
// Preemptive SJF scheduler built as a chain of task cells with a tick sequencer.
// ----------------------------------------------------------------------------
// A load beat (tuser = 0) writes one task slot and returns no result. A tick
// beat (tuser = 1) returns exactly one result beat. Each slot lives in its
// own cell; the cells form a registered chain through which the best
// candidate so far (least remaining work among arrived, unfinished slots,
// lowest index on a tie) and a saturating pending count move one cell per
// cycle. A tick therefore passes through the scan state, in which the
// candidate travels the chain, the calc state, which advances the clock and
// forms the turnaround time, and the done state, which forms the wait time
// and commits the result. The input is ready again in the cycle after the
// commit; the block takes no beat while a tick is in flight. The result sits
// in an output register, so the next beat is accepted while it waits; a
// following tick only holds in its commit cycle until that register is free.
// The task_count register is written through task_count_we and
// task_count_wdata; the user must do so only while the block is idle, as the
// block itself does not enforce this. Values above MAX_TASKS act as
// MAX_TASKS. Slot contents have no reset; a tick that reads a slot in use
// that was never loaded gives an undefined result.
module shortest_remaining_time_scheduler_top #(
	parameter int unsigned MAX_TASKS = 16,
	parameter int unsigned TIME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration.
	input  logic        task_count_we,
	input  logic [4:0]  task_count_wdata,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // task_index[3:0], arrival_time[19:4],
	                              // burst_length[35:20], zero[39:36]
	input  logic        s_tuser,  // req_type
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // running_task[3:0], cpu_idle[4],
	                              // remaining_after[20:5], switched[21],
	                              // task_done[22], wait_time[38:23],
	                              // turn_time[54:39],
	                              // switch_total[70:55], all_done[71]
);
	import srtf_pkg::*;

	localparam int unsigned IDX_W  = $clog2(MAX_TASKS);
	localparam int unsigned PICK_W = $clog2(MAX_TASKS + 1);
	localparam int unsigned TW     = (TIME_BITS > DATA_W) ? TIME_BITS : DATA_W;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
	localparam logic [PICK_W-1:0]    NO_PICK  = PICK_W'(MAX_TASKS);
	localparam logic [IDX_W-1:0]     SCAN_END = IDX_W'(MAX_TASKS - 1);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]           state_q;
	logic [IDX_W-1:0]     scan_cnt_q;
	logic [COUNT_W-1:0]   task_count_q;
	logic [TIME_BITS-1:0] time_q;
	logic [PICK_W-1:0]    prev_pick_q;
	logic [DATA_W-1:0]    switch_cnt_q;

	// Captured pick, held from the calculation to the commit cycle.
	srtf_link_t           pick_s1;
	logic [IDX_W-1:0]     pick_idx_s1;
	logic [TW-1:0]        turn_s1;

	logic                 m_valid_q;
	logic [71:0]          m_data_q;

	srtf_load_t           load;
	logic                 dec_en;
	srtf_link_t           link [MAX_TASKS+1];
	logic [IDX_W-1:0]     lidx [MAX_TASKS+1];

	logic                 s_accept;
	logic                 out_free;
	logic                 commit;
	logic [TIME_BITS-1:0] time_nx;
	logic [TW-1:0]        turn_nx;
	logic [TW-1:0]        wait_nx;
	logic [PICK_W-1:0]    pick_code;
	logic                 switched;
	logic                 done;
	logic [DATA_W-1:0]    rem_after;
	logic [DATA_W-1:0]    wait_out;
	logic [DATA_W-1:0]    turn_out;
	logic [DATA_W-1:0]    switch_nx;
	logic                 all_done;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign commit   = (state_q == ST_DONE) && out_free;
	assign dec_en   = commit && pick_s1.found;

	always_comb begin
		load.en    = s_accept && (s_tuser == REQ_LOAD);
		load.index = s_tdata[3:0];
		load.arr   = s_tdata[19:4];
		load.bur   = s_tdata[35:20];
	end

	// The chain starts from an empty candidate.
	assign link[0] = '0;
	assign lidx[0] = '0;

	for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
		srtf_cell #(
			.MAX_TASKS (MAX_TASKS),
			.IDX       (k),
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.task_count (task_count_q),
			.time_now   (time_q),
			.load       (load),
			.dec_en     (dec_en),
			.dec_idx    (pick_idx_s1),
			.link_in    (link[k]),
			.idx_in     (lidx[k]),
			.link_out   (link[k+1]),
			.idx_out    (lidx[k+1])
		);
	end

	// The clock advances when some slot in use still has work, and the
	// turnaround time is taken against the advanced clock.
	always_comb begin
		time_nx = time_q;
		if ((link[MAX_TASKS].pend != 2'd0) && (time_q != TIME_MAX)) begin
			time_nx = time_q + 1'b1;
		end
		if (TW'(time_nx) > TW'(link[MAX_TASKS].arr)) begin
			turn_nx = TW'(time_nx) - TW'(link[MAX_TASKS].arr);
		end else begin
			turn_nx = '0;
		end
	end

	always_comb begin
		pick_code = pick_s1.found ? PICK_W'(pick_idx_s1) : NO_PICK;
		switched  = (pick_code != prev_pick_q);
		done      = pick_s1.found && (pick_s1.rem == DATA_W'(1));
		rem_after = pick_s1.found ? (pick_s1.rem - 1'b1) : '0;
		if (turn_s1 > TW'(pick_s1.bur)) begin
			wait_nx = turn_s1 - TW'(pick_s1.bur);
		end else begin
			wait_nx = '0;
		end
		turn_out = (turn_s1 > TW'(DATA_MAX)) ? DATA_MAX : turn_s1[DATA_W-1:0];
		wait_out = (wait_nx > TW'(DATA_MAX)) ? DATA_MAX : wait_nx[DATA_W-1:0];
		if (!done) begin
			turn_out = '0;
			wait_out = '0;
		end
		switch_nx = switch_cnt_q;
		if (switched && (switch_cnt_q != DATA_MAX)) begin
			switch_nx = switch_cnt_q + 1'b1;
		end
		// Only a finishing pick can drop the last pending slot.
		all_done = (pick_s1.pend == 2'd0) || ((pick_s1.pend == 2'd1) && done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_cnt_q   <= '0;
			task_count_q <= '0;
			time_q       <= '0;
			prev_pick_q  <= '0;
			switch_cnt_q <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (task_count_we) begin
				task_count_q <= task_count_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					scan_cnt_q <= '0;
					if (s_accept && (s_tuser == REQ_TICK)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_cnt_q == SCAN_END) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					time_q  <= time_nx;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						prev_pick_q  <= pick_code;
						switch_cnt_q <= switch_nx;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			pick_s1     <= link[MAX_TASKS];
			pick_idx_s1 <= lidx[MAX_TASKS];
			turn_s1     <= turn_nx;
		end
		if (commit) begin
			m_data_q <= {all_done, switch_nx, turn_out, wait_out, done, switched,
			             rem_after, !pick_s1.found,
			             pick_s1.found ? SLOT_W'(pick_idx_s1) : SLOT_W'(0)};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== tb/srtf_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SRTF scheduler result checker
// Watches the register port and both streams of the scheduler, keeps its own
// copy of the task table and clock, predicts the result of every tick beat and
// compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module srtf_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            task_count_we,
	input  logic [srtf_pkg::COUNT_W-1:0]    task_count_wdata,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [39:0]                     s_tdata,   // task_index, arrival_time,
	                                                   // burst_length, zero
	input  logic                            s_tuser,   // req_type
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [71:0]                     m_tdata,   // running_task .. all_done,
	                                                   // see sched_result_t
	input  logic                            run_done,
	output int                              open_ticks,
	output logic [srtf_pkg::DATA_W-1:0]     sched_clock,
	output int                              failures
);
	import srtf_pkg::*;

	localparam int SLOTS = 1 << SLOT_W;
	localparam logic [COUNT_W-1:0] NO_PICK = COUNT_W'(SLOTS);
	localparam int REPORT_MAX = 10;

	// Result fields, lowest bits last.
	typedef struct packed {
		logic              all_done;
		logic [DATA_W-1:0] switch_total;
		logic [DATA_W-1:0] turn_time;
		logic [DATA_W-1:0] wait_time;
		logic              task_done;
		logic              switched;
		logic [DATA_W-1:0] remaining_after;
		logic              cpu_idle;
		logic [SLOT_W-1:0] running_task;
	} sched_result_t;

	logic [DATA_W-1:0]  work_left [SLOTS];
	logic [DATA_W-1:0]  arrival_at [SLOTS];
	logic [DATA_W-1:0]  burst_of [SLOTS];
	logic [COUNT_W-1:0] task_count;
	logic [COUNT_W-1:0] last_pick;
	logic [DATA_W-1:0]  switch_count;
	sched_result_t      tick_results_due [$];
	int                 mismatches;
	int                 beats_seen;

	assign failures = mismatches + (run_done ? open_ticks : 0);

	function automatic string describe(sched_result_t r);
		return $sformatf({"task=%0d idle=%0b rem=%0d sw=%0b done=%0b wait=%0d",
			" turn=%0d switches=%0d all_done=%0b"}, r.running_task, r.cpu_idle,
			r.remaining_after, r.switched, r.task_done, r.wait_time,
			r.turn_time, r.switch_total, r.all_done);
	endfunction

	// One scheduling tick: pick the arrived, unfinished slot with the least work.
	task automatic schedule_tick(output sched_result_t r);
		int                n;
		logic [COUNT_W-1:0] pick;
		logic [DATA_W-1:0] best;
		logic              waiting;
		logic [DATA_W-1:0] turn;
		r = '0;
		n = (task_count > SLOTS) ? SLOTS : int'(task_count);
		pick = NO_PICK;
		best = '0;
		waiting = 1'b0;
		for (int j = 0; j < n; j++) begin
			if (work_left[j] != '0) begin
				waiting = 1'b1;
				if (arrival_at[j] <= sched_clock && (pick == NO_PICK || work_left[j] < best)) begin
					pick = COUNT_W'(j);
					best = work_left[j];
				end
			end
		end
		r.switched = (pick != last_pick);
		if (r.switched && switch_count != DATA_MAX)
			switch_count++;
		last_pick = pick;
		if (waiting && sched_clock != DATA_MAX)
			sched_clock++;
		if (pick == NO_PICK) begin
			r.cpu_idle = 1'b1;
		end else begin
			work_left[pick[SLOT_W-1:0]]--;
			r.running_task = pick[SLOT_W-1:0];
			r.remaining_after = work_left[pick[SLOT_W-1:0]];
			if (work_left[pick[SLOT_W-1:0]] == '0) begin
				r.task_done = 1'b1;
				turn = (sched_clock > arrival_at[pick[SLOT_W-1:0]]) ?
					sched_clock - arrival_at[pick[SLOT_W-1:0]] : '0;
				r.turn_time = turn;
				r.wait_time = (turn > burst_of[pick[SLOT_W-1:0]]) ?
					turn - burst_of[pick[SLOT_W-1:0]] : '0;
			end
		end
		r.switch_total = switch_count;
		r.all_done = 1'b1;
		for (int j = 0; j < n; j++)
			if (work_left[j] != '0)
				r.all_done = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sched_result_t due;
		sched_result_t got;
		string         diffs;
		if (!arst_n) begin
			for (int j = 0; j < SLOTS; j++) begin
				work_left[j] = '0;
				arrival_at[j] = '0;
				burst_of[j] = '0;
			end
			task_count = '0;
			last_pick = '0;
			switch_count = '0;
			sched_clock = '0;
			tick_results_due.delete();
			open_ticks = 0;
			mismatches = 0;
			beats_seen = 0;
		end else begin
			if (task_count_we)
				task_count = task_count_wdata;
			if (s_tvalid && s_tready) begin
				if (s_tuser == REQ_LOAD) begin
					arrival_at[s_tdata[3:0]] = s_tdata[19:4];
					burst_of[s_tdata[3:0]] = s_tdata[35:20];
					work_left[s_tdata[3:0]] = s_tdata[35:20];
				end else begin
					schedule_tick(due);
					tick_results_due.push_back(due);
				end
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				beats_seen++;
				if (tick_results_due.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("result beat %0d arrived with no tick waiting: %s",
							beats_seen, describe(got));
					mismatches++;
				end else begin
					due = tick_results_due.pop_front();
					diffs = "";
					if (got.running_task !== due.running_task)
						diffs = {diffs, " running_task"};
					if (got.cpu_idle !== due.cpu_idle)
						diffs = {diffs, " cpu_idle"};
					if (got.remaining_after !== due.remaining_after)
						diffs = {diffs, " remaining_after"};
					if (got.switched !== due.switched)
						diffs = {diffs, " switched"};
					if (got.task_done !== due.task_done)
						diffs = {diffs, " task_done"};
					if (got.wait_time !== due.wait_time)
						diffs = {diffs, " wait_time"};
					if (got.turn_time !== due.turn_time)
						diffs = {diffs, " turn_time"};
					if (got.switch_total !== due.switch_total)
						diffs = {diffs, " switch_total"};
					if (got.all_done !== due.all_done)
						diffs = {diffs, " all_done"};
					if (diffs != "") begin
						if (mismatches < REPORT_MAX) begin
							$display("result beat %0d differs in%s", beats_seen, diffs);
							$display("  expected %s", describe(due));
							$display("  actual   %s", describe(got));
						end
						mismatches++;
					end
				end
			end
			open_ticks = tick_results_due.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SRTF scheduler testbench
// Drives load and tick beats into the scheduler with random gaps and output
// back-pressure, walks it through many task-count settings and task sets, and
// takes its verdict from a checker that predicts every tick result.
// ----------------------------------------------------------------------------
module testbench;

	import srtf_pkg::*;

	// Random part length, in input beats.
	localparam int ITEMS = 1600;
	// The drain wait leaves a margin on top of a tick's run through the block.
	localparam int DRAIN_CYCLES = 30;
	// Cycles with no beat on either stream before the run is declared hung. The
	// longest honest quiet stretch is the long receiver hold-off.
	localparam int QUIET_LIMIT = 3000;
	// The receiver holds off once, for this many cycles, after this many beats.
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 400;

	logic               clk;
	logic               arst_n;
	logic               task_count_we;
	logic [COUNT_W-1:0] task_count_wdata;
	logic               s_tvalid;
	logic               s_tready;
	logic [39:0]        s_tdata;   // task_index[3:0], arrival_time[19:4],
	                               // burst_length[35:20], zero[39:36]
	logic               s_tuser;   // req_type
	logic               m_tvalid;
	logic               m_tready;
	logic [71:0]        m_tdata;   // running_task[3:0], cpu_idle[4],
	                               // remaining_after[20:5], switched[21],
	                               // task_done[22], wait_time[38:23],
	                               // turn_time[54:39],
	                               // switch_total[70:55], all_done[71]
	logic               run_done;
	int                 open_ticks;
	logic [DATA_W-1:0]  sched_clock;
	int                 failures;

	// When set, neither side inserts gaps, so beats go back to back.
	logic               steady;
	int                 sent_count;
	int unsigned        quiet_cycles;

	shortest_remaining_time_scheduler_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.task_count_we    (task_count_we),
		.task_count_wdata (task_count_wdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata)
	);

	srtf_result_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.task_count_we    (task_count_we),
		.task_count_wdata (task_count_wdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.run_done         (run_done),
		.open_ticks       (open_ticks),
		.sched_clock      (sched_clock),
		.failures         (failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one beat after a random gap and returns at the edge that takes it.
	// Valid is only lowered when a gap is drawn, so back-to-back beats keep it
	// high across the edge instead of dropping and raising it in one step.
	task automatic offer_request(input logic kind, input logic [SLOT_W-1:0] idx,
		input logic [DATA_W-1:0] arr, input logic [DATA_W-1:0] bur);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'b0000, bur, arr, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_count++;
	endtask

	task automatic offer_load(input int idx, input logic [DATA_W-1:0] arr,
		input logic [DATA_W-1:0] bur);
		offer_request(REQ_LOAD, SLOT_W'(idx), arr, bur);
	endtask

	// A tick ignores its data bits, so they carry random noise.
	task automatic offer_tick();
		offer_request(REQ_TICK, SLOT_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
	endtask

	// Stops offering and waits until every tick result is in, then lets the
	// pipeline run empty in case the last beat was a load still being applied.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (open_ticks != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The register may only change while the scheduler is idle.
	task automatic set_task_count(input int value);
		settle();
		task_count_we <= 1'b1;
		task_count_wdata <= COUNT_W'(value);
		@(posedge clk);
		task_count_we <= 1'b0;
	endtask

	// Most tasks arrive now or a few ticks ahead of the predicted clock, some
	// in the past, and a few anywhere in the 16-bit range.
	function automatic logic [DATA_W-1:0] pick_arrival();
		int roll;
		int ahead;
		roll = $urandom_range(0, 9);
		if (roll < 6) begin
			ahead = int'(sched_clock) + $urandom_range(0, 6);
			return (ahead > int'(DATA_MAX)) ? DATA_MAX : DATA_W'(ahead);
		end else if (roll < 9) begin
			return DATA_W'($urandom_range(0, sched_clock));
		end
		return DATA_W'($urandom_range(0, 65535));
	endfunction

	// Short bursts keep runs finishing; zero and full-range bursts are mixed in.
	function automatic logic [DATA_W-1:0] pick_burst();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 2)
			return '0;
		else if (roll == 2)
			return DATA_W'($urandom_range(0, 65535));
		return DATA_W'($urandom_range(1, 5));
	endfunction

	// Receiver: a random number of held-off cycles before each result beat,
	// none in steady stretches, and one long hold-off that backs the block up
	// until it refuses input while the sender keeps offering ticks.
	initial begin : receiver
		int wait_cycles;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			wait_cycles = steady ? 0 : $urandom_range(0, 10);
			if (taken == HOLD_AT)
				wait_cycles = HOLD_CYCLES;
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			taken++;
		end
	end

	// Watchdog: the run is hung when neither stream moves for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int count;
		int slots;
		int work;
		int ticks;
		int roll;
		logic [DATA_W-1:0] bur;

		arst_n <= 1'b0;
		task_count_we <= 1'b0;
		task_count_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= REQ_LOAD;
		m_tready <= 1'b0;
		run_done <= 1'b0;
		steady = 1'b0;
		sent_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With no slot in use a tick is an idle tick that ends
		// the run at once and leaves the clock where it is.
		set_task_count(0);
		offer_tick();

		// Four slots: two equal tasks arriving at tick 2, a zero-burst slot,
		// and a slot with both fields at their maximum that never arrives.
		set_task_count(4);
		offer_load(0, 16'd2, 16'd2);
		offer_load(1, 16'd2, 16'd2);
		offer_load(2, 16'd0, 16'd0);
		offer_load(3, DATA_MAX, DATA_MAX);
		// Two idle ticks while the clock walks up to the arrivals, then the tie
		// goes to the lower slot, which runs to completion.
		repeat (4) offer_tick();
		// Reload the finished zero-burst slot mid-run with a short task that is
		// already overdue; it preempts the remaining tie partner.
		offer_load(2, 16'd0, 16'd1);
		// The short task runs, the other tie partner finishes, and then only the
		// never-arriving slot is left, so the CPU idles while the clock runs on.
		repeat (4) offer_tick();

		// Shrink the slot range so everything in use is finished: the tick is
		// idle, the clock holds and the run reports all done.
		set_task_count(2);
		offer_tick();
		// A burst at the field maximum shows the highest remaining work.
		offer_load(0, 16'd0, DATA_MAX);
		repeat (2) offer_tick();

		// Random part: phases of one task-count setting each. A phase loads
		// every slot in use with fresh content, so no tick ever reads a slot
		// that was never written, then ticks the run, sometimes cut short and
		// sometimes with a reload or a stray load mixed in.
		sent_count = 0;
		while (sent_count < ITEMS) begin
			roll = $urandom_range(0, 9);
			if (roll == 0)
				count = 0;
			else if (roll == 1)
				count = 16;
			else if (roll == 2)
				count = 31;
			else if (roll == 3)
				count = $urandom_range(17, 30);
			else
				count = $urandom_range(1, 6);
			set_task_count(count);
			steady = ($urandom_range(0, 4) == 0);
			slots = (count > 16) ? 16 : count;
			work = 8;
			for (int s = 0; s < slots; s++) begin
				bur = pick_burst();
				offer_load(s, pick_arrival(), bur);
				work += (bur > 16'd8) ? 10 : int'(bur);
			end
			if (work > 90)
				work = 90;
			ticks = $urandom_range(work / 2, work);
			for (int t = 0; t < ticks; t++) begin
				if ($urandom_range(0, 19) == 0)
					offer_load($urandom_range(0, 15), pick_arrival(), pick_burst());
				offer_tick();
			end
			steady = 1'b0;
		end

		// Wait for the last results, then take the verdict.
		settle();
		run_done <= 1'b1;
		@(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/srtf_pkg.sv
hw/rtl/srtf_cell.sv
hw/rtl/shortest_remaining_time_scheduler_top.sv
tb/srtf_result_checker.sv
tb/testbench.sv
